/* sv/segmented_prime_sieve_macros.svh */
// ----------------------------------------------------------------------------
// Segmented prime sieve: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_PRIME_SIEVE_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under reset
`define SPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication under reset
`define SPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define SPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/sps_pkg.sv */
// ----------------------------------------------------------------------------
// Segmented prime sieve package
// Widths, limits and item types shared by the sieve design.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Value and window limits
    localparam int VALUE_BITS   = 20;
    localparam int SEGMENT_SIZE = 64;
    localparam int MASK_BITS    = 64;
    localparam int OFF_BITS     = $clog2(MASK_BITS);

    // Sieving base: up to sqrt of the largest value, plus one odd step
    localparam int BASE_BITS    = VALUE_BITS / 2 + 1;
    localparam int SQ_BITS      = 2 * BASE_BITS;
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

    // Input item
    typedef struct packed {
        logic [VALUE_BITS-1:0] range_low;
        logic [VALUE_BITS-1:0] range_high;
    } t_sieve_in;

    // Result item
    typedef struct packed {
        logic [MASK_BITS-1:0] prime_mask;
        logic                 range_error;
    } t_sieve_out;

endpackage

/* sv/segmented_prime_sieve.sv */
// Flow: for a rejected window the result appears in the cycle after accept; otherwise
//   the sequencer sweeps each base with a square, a test, a bit-serial remainder pass,
//   a start and a marking pass over the multiples in the window. Bases are 2 and the
//   odd numbers up to sqrt(range_high).
// Throughput: one item at a time; the next item is taken once the result leaves.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle, no result.
// ----------------------------------------------------------------------------
// Segmented prime sieve
// Marks the primes of a window of up to SEGMENT_SIZE integers by sweeping each
// base with one shared remainder step and one marking adder under a sequencer.
// ----------------------------------------------------------------------------
`include "segmented_prime_sieve_macros.svh"

module segmented_prime_sieve
    import sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_sieve_in  i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sieve_out o_item
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_TEST  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_START = 7'b0010000,
        S_MARK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_lo, n_lo;
    logic [VALUE_BITS-1:0]   r_hi, n_hi;
    logic [MASK_BITS-1:0]    r_mask, n_mask;
    logic                    r_err, n_err;
    logic [BASE_BITS-1:0]    r_base, n_base;
    logic [SQ_BITS-1:0]      r_sq, n_sq;
    logic [BASE_BITS-1:0]    r_rem, n_rem;
    logic [VALUE_BITS-1:0]   r_dvd, n_dvd;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [SQ_BITS-1:0]      r_j, n_j;

    logic                    w_accept;
    logic [VALUE_BITS-1:0]   w_diff;
    logic                    w_bad;
    logic [MASK_BITS-1:0]    w_init_mask;
    logic [BASE_BITS-1:0]    w_rem_sh;
    logic [SQ_BITS-1:0]      w_first;
    logic [SQ_BITS-1:0]      w_hi_ext;
    logic [SQ_BITS-1:0]      w_off;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign w_accept = i_valid && o_ready;

    // Window checks and initial mask of window width
    assign w_diff   = i_item.range_high - i_item.range_low;
    assign w_bad    = (i_item.range_high < i_item.range_low) ||
                      (w_diff >= VALUE_BITS'(SEGMENT_SIZE));
    always_comb begin
        w_init_mask = {MASK_BITS{1'b1}} >> (OFF_BITS'(MASK_BITS - 1) - w_diff[OFF_BITS-1:0]);
        // Zero and one are never prime
        if (i_item.range_low == '0) begin
            w_init_mask[1:0] = 2'b00;
        end else if (i_item.range_low == VALUE_BITS'(1)) begin
            w_init_mask[0] = 1'b0;
        end
    end

    // Shared step datapath
    assign w_rem_sh = {r_rem[BASE_BITS-2:0], r_dvd[VALUE_BITS-1]};
    assign w_first  = SQ_BITS'(r_lo) +
                      ((r_rem == '0) ? '0 : SQ_BITS'(r_base - r_rem));
    assign w_hi_ext = SQ_BITS'(r_hi);
    assign w_off    = r_j - SQ_BITS'(r_lo);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mask  = r_mask;
        n_err   = r_err;
        n_base  = r_base;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_j     = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_lo   = i_item.range_low;
                    n_hi   = i_item.range_high;
                    n_base = BASE_BITS'(2);
                    if (w_bad) begin
                        n_err   = 1'b1;
                        n_mask  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_mask  = w_init_mask;
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                // Square of the current base
                n_sq    = SQ_BITS'(r_base) * SQ_BITS'(r_base);
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_sq > w_hi_ext) begin
                    n_state = S_DONE;
                end else begin
                    n_rem   = '0;
                    n_dvd   = r_lo;
                    n_cnt   = DIV_CNT_BITS'(VALUE_BITS);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring remainder step of low mod base
                n_rem   = (w_rem_sh >= r_base) ? (w_rem_sh - r_base) : w_rem_sh;
                n_dvd   = {r_dvd[VALUE_BITS-2:0], 1'b0};
                n_cnt   = r_cnt - DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                // Start at the larger of the first multiple and the square
                n_j     = (w_first > r_sq) ? w_first : r_sq;
                n_state = S_MARK;
            end
            S_MARK: begin
                if (r_j > w_hi_ext) begin
                    // Advance: 2, then odd bases only
                    n_base  = (r_base == BASE_BITS'(2)) ? BASE_BITS'(3)
                                                        : r_base + BASE_BITS'(2);
                    n_state = S_SQ;
                end else begin
                    n_mask[w_off[OFF_BITS-1:0]] = 1'b0;
                    n_j = r_j + SQ_BITS'(r_base);
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mask <= n_mask;
        r_err  <= n_err;
        r_base <= n_base;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_cnt  <= n_cnt;
        r_j    <= n_j;
    end

    assign o_item.prime_mask  = r_mask;
    assign o_item.range_error = r_err;

    // Checks
    `SPS_ASSERT_IMP(a_err_zero_mask, i_clk, i_rst_n, o_valid && r_err, r_mask == '0)
    `SPS_ASSERT_IMP(a_rem_below_base, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_base)
    `SPS_ASSERT_IMP(a_mark_in_window, i_clk, i_rst_n, r_state == S_MARK, r_j >= SQ_BITS'(r_lo))
    `SPS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_ready)

endmodule
